>>> hw/rtl/ptmw_pkg.sv
// Shared types and constants for the page table map walker.
package ptmw_pkg;

  localparam int TABLE_PAGES_DEF   = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int VA_W              = 48;
  localparam int PA_W              = 52;
  localparam int DATA_W            = 64;

  localparam int VA_L4_LSB   = 39;
  localparam int VA_L3_LSB   = 30;
  localparam int VA_L2_LSB   = 21;
  localparam int VA_LEAF_LSB = 12;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES_PER_TABLE - 1);

  localparam logic [1:0] LVL_TOP  = 2'd0;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_LAST = 2'd2;

  localparam logic [1:0] ST_MAPPED   = 2'd0;
  localparam logic [1:0] ST_SKIPPED  = 2'd1;
  localparam logic [1:0] ST_NO_PAGES = 2'd2;
  localparam logic [1:0] ST_OUTSIDE  = 2'd3;

  localparam logic [DATA_W-1:0] FLAG_PRESENT_RW = DATA_W'(3);

  typedef struct packed {
    logic [63:0] virtual_address;
    logic [51:0] physical_address;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] leaf_entry;
    logic [1:0]  tables_added;
  } result_t;

endpackage

>>> hw/rtl/ptmw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptmw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ptmw_link_unit.sv
// Link arithmetic: builds a link entry for a fresh page and resolves an entry to a page.
module ptmw_link_unit #(
  parameter int TABLE_PAGES = 64,
  parameter int PAGE_W      = 6
) (
  input  logic [51:0]       base,
  input  logic [63:0]       entry,
  input  logic [PAGE_W-1:0] fresh,
  output logic [63:0]       link,
  output logic [PAGE_W-1:0] page,
  output logic              in_range
);

  logic [39:0] off;
  logic [39:0] link_pfn;

  // page offset modulo 2^52, page granular
  assign off      = entry[51:12] - base[51:12];
  assign in_range = off < 40'(TABLE_PAGES);
  assign page     = off[PAGE_W-1:0];

  assign link_pfn = base[51:12] + 40'(fresh);
  assign link     = {12'd0, link_pfn, 12'h003};

endmodule

>>> hw/rtl/page_table_map_walker_top.sv
// Top level of the page table map walker: sequencer, table store and config register.
//
// One map request is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high, and cannot be held off by the receiver.
// After reset the block sweeps the whole table store to zero, one entry per cycle, with
// busy high; table_base may be written during that time.
// A request with any of virtual bits 48..56 set gives its result in the cycle after
// the transfer. Otherwise the walk reads the three upper levels one after another
// through the single store read port (a read state and a check state per level) and
// writes the leaf. Each missing level adds a new table, zeroed entry by entry through
// the single write port, and then a write of the link. The next request may be
// started in the cycle the result is shown. table_base is written through the cfg
// channel, which is always ready; write it only while busy is low and no result is due.
module page_table_map_walker_top #(
  parameter int TABLE_PAGES = ptmw_pkg::TABLE_PAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ptmw_pkg::request_t request,
  output logic              done,
  output ptmw_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [51:0]       cfg_data
);

  import ptmw_pkg::*;

  localparam int DEPTH  = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PAGE_W = $clog2(TABLE_PAGES);
  localparam int NFP_W  = $clog2(TABLE_PAGES + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_ZERO,
    S_LINK,
    S_LEAF
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   clr;
  logic [1:0]          lvl;
  logic [PAGE_W-1:0]   page;
  logic [PAGE_W-1:0]   fresh;
  logic [NFP_W-1:0]    nfp;
  logic [IDX_W-1:0]    zidx;
  logic [1:0]          added;
  logic [VA_W-1:0]     va;
  logic [PA_W-1:0]     pa;
  logic [51:0]         table_base;

  logic [IDX_W-1:0]    lvl_idx;
  logic [IDX_W-1:0]    leaf_idx;
  logic [DATA_W-1:0]   leaf_val;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;
  logic [DATA_W-1:0]   link;
  logic [PAGE_W-1:0]   res_page;
  logic                res_ok;

  // table_base register; the user must make cfg writes only while idle, the block itself does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      table_base <= cfg_data;
    end
  end

  // table index for the current level
  always_comb begin
    case (lvl)
      LVL_TOP:  lvl_idx = IDX_W'(va >> VA_L4_LSB);
      LVL_MID:  lvl_idx = IDX_W'(va >> VA_L3_LSB);
      default:  lvl_idx = IDX_W'(va >> VA_L2_LSB);
    endcase
  end

  assign leaf_idx  = IDX_W'(va >> VA_LEAF_LSB);
  assign leaf_val  = {{(DATA_W - PA_W){1'b0}}, pa} | FLAG_PRESENT_RW;
  assign ram_raddr = {page, lvl_idx};

  // store write port: clearing sweep, table zeroing, link write, leaf write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {page, lvl_idx};
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
      end
      S_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = {fresh, zidx};
      end
      S_LINK: begin
        ram_we    = 1'b1;
        ram_wdata = link;
      end
      S_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = {page, leaf_idx};
        ram_wdata = leaf_val;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ptmw_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ptmw_link_unit #(
    .TABLE_PAGES(TABLE_PAGES),
    .PAGE_W     (PAGE_W)
  ) u_link (
    .base    (table_base),
    .entry   (ram_rdata),
    .fresh   (fresh),
    .link    (link),
    .page    (res_page),
    .in_range(res_ok)
  );

  assign busy = (state != S_IDLE);

  // walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      nfp   <= NFP_W'(1);
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + ADDR_W'(1);
          if (clr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            va    <= request.virtual_address[VA_W-1:0];
            pa    <= request.physical_address;
            lvl   <= LVL_TOP;
            page  <= '0;
            added <= '0;
            if (request.virtual_address[56:48] != '0) begin
              done                <= 1'b1;
              result.status       <= ST_SKIPPED;
              result.leaf_entry   <= '0;
              result.tables_added <= '0;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (ram_rdata[0]) begin
            if (res_ok) begin
              page <= res_page;
              if (lvl == LVL_LAST) begin
                state <= S_LEAF;
              end else begin
                lvl   <= lvl + 2'd1;
                state <= S_READ;
              end
            end else begin
              done                <= 1'b1;
              result.status       <= ST_OUTSIDE;
              result.leaf_entry   <= '0;
              result.tables_added <= added;
              state               <= S_IDLE;
            end
          end else if (nfp >= NFP_W'(TABLE_PAGES)) begin
            done                <= 1'b1;
            result.status       <= ST_NO_PAGES;
            result.leaf_entry   <= '0;
            result.tables_added <= added;
            state               <= S_IDLE;
          end else begin
            fresh <= nfp[PAGE_W-1:0];
            nfp   <= nfp + NFP_W'(1);
            zidx  <= '0;
            state <= S_ZERO;
          end
        end
        S_ZERO: begin
          zidx <= zidx + IDX_W'(1);
          if (zidx == IDX_LAST) begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          added <= added + 2'd1;
          page  <= fresh;
          if (lvl == LVL_LAST) begin
            state <= S_LEAF;
          end else begin
            lvl   <= lvl + 2'd1;
            state <= S_READ;
          end
        end
        S_LEAF: begin
          done                <= 1'b1;
          result.status       <= ST_MAPPED;
          result.leaf_entry   <= leaf_val;
          result.tables_added <= added;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result follows either a transfer or a busy cycle
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy || start))
    else $error("result without a request in flight");

  // the allocator never runs past the store
  assert property (@(posedge clk) disable iff (rst) nfp <= NFP_W'(TABLE_PAGES))
    else $error("page allocator beyond store");

  // mapped results carry present and writable; others carry zero
  assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.status == ST_MAPPED && result.leaf_entry[1:0] == 2'b11) ||
              (result.status != ST_MAPPED && result.leaf_entry == '0)))
    else $error("leaf entry does not match status");

  // a high-index request is answered as skipped in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.virtual_address[56:48] != '0) |=>
      (done && result.status == ST_SKIPPED && result.tables_added == '0))
    else $error("skipped request not reported at once");

endmodule

>>> tb/page_table_map_walker_checker.sv
// Checker for the page table map walker: tracks the table store, predicts each result, compares.
module page_table_map_walker_checker #(
  parameter int TABLE_PAGES = ptmw_pkg::TABLE_PAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  ptmw_pkg::request_t request,
  input  logic               done,
  input  ptmw_pkg::result_t  result,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [51:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  import ptmw_pkg::*;

  logic [DATA_W-1:0] page_store [TABLE_PAGES*ENTRIES_PER_TABLE];
  int unsigned       next_page;
  logic [PA_W-1:0]   table_base;
  result_t           expected_results [$];
  result_t           oldest;
  int unsigned       k;

  function automatic logic [PA_W-1:0] aligned_base();
    return {table_base[PA_W-1:12], 12'h0};
  endfunction

  // Walks and updates the shadow store the way the block should, returns its result.
  function automatic result_t map_request(request_t req);
    result_t         res;
    logic [63:0]     va;
    logic [PA_W-1:0] offset;
    logic [PA_W-1:0] link_addr;
    int unsigned     page;
    int unsigned     slot;
    int unsigned     fresh;
    int unsigned     lvl;
    int unsigned     e;
    res = '0;
    res.status = ST_MAPPED;
    va = req.virtual_address;
    page = 0;
    if (va[56:48] != '0) begin
      res.status = ST_SKIPPED;
      return res;
    end
    for (lvl = 0; lvl < 3; lvl++) begin
      // upper level indices sit at bits 39, 30 and 21
      slot = page * ENTRIES_PER_TABLE + va[VA_L4_LSB - IDX_W * lvl +: IDX_W];
      if (!page_store[slot][0]) begin
        if (next_page >= TABLE_PAGES) begin
          res.status = ST_NO_PAGES;
          break;
        end
        fresh = next_page;
        next_page++;
        for (e = 0; e < ENTRIES_PER_TABLE; e++)
          page_store[fresh * ENTRIES_PER_TABLE + e] = '0;
        link_addr = aligned_base() + (PA_W'(fresh) << 12);
        page_store[slot] = DATA_W'(link_addr) | FLAG_PRESENT_RW;
        res.tables_added = res.tables_added + 2'd1;
      end
      // link address relative to the store base, wrapping at 52 bits
      offset = {page_store[slot][PA_W-1:12], 12'h0} - aligned_base();
      if (offset[PA_W-1:12] >= TABLE_PAGES) begin
        res.status = ST_OUTSIDE;
        break;
      end
      page = 32'(offset[PA_W-1:12]);
    end
    if (res.status == ST_MAPPED) begin
      res.leaf_entry = DATA_W'(req.physical_address) | FLAG_PRESENT_RW;
      page_store[page * ENTRIES_PER_TABLE + va[VA_LEAF_LSB +: IDX_W]] = res.leaf_entry;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (k = 0; k < TABLE_PAGES * ENTRIES_PER_TABLE; k++)
        page_store[k] = '0;
      next_page  = 1;
      table_base = '0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d leaf_entry %h tables_added %0d",
                 result.status, result.leaf_entry, result.tables_added);
          errors++;
        end else begin
          oldest = expected_results.pop_front();
          if (result.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, result.status);
            errors++;
          end
          if (result.leaf_entry !== oldest.leaf_entry) begin
            $error("leaf_entry: expected %h, got %h", oldest.leaf_entry, result.leaf_entry);
            errors++;
          end
          if (result.tables_added !== oldest.tables_added) begin
            $error("tables_added: expected %0d, got %0d",
                   oldest.tables_added, result.tables_added);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready)
        table_base = cfg_data;
      if (start && !busy)
        expected_results.push_back(map_request(request));
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/tb.sv
// Testbench top for the page table map walker: clock, reset, stimulus and verdict.
module tb;
  import ptmw_pkg::*;

  localparam int PAGES            = TABLE_PAGES_DEF;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int PHASES           = 5;

  logic            clk = 1'b0;
  logic            rst;
  logic            start;
  logic            busy;
  request_t        request;
  logic            done;
  result_t         result;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [PA_W-1:0] cfg_data;
  int              errors;
  int              pending;

  // transfers still to come in the current run of back-to-back transfers
  int              calm_left;
  // table_base used for each random phase
  logic [PA_W-1:0] phase_base [PHASES];

  page_table_map_walker_top #(
    .TABLE_PAGES(PAGES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // The checker sees the same pins; it owns prediction and comparison.
  page_table_map_walker_checker #(
    .TABLE_PAGES(PAGES)
  ) u_checker (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop. Slowest honest run: the store sweep after reset, 63 table allocations
  // and ~1000 requests with idle gaps between them; the limit leaves plenty of room.
  initial begin
    #4_000_000;
    $display("** page_table_map_walker_top: FAILED **");
    $finish;
  end

  // Idle time before the next request: mostly none or short, now and then long,
  // and occasionally a run of back-to-back transfers.
  function automatic int pick_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic request_t mapping(logic [63:0] va, logic [PA_W-1:0] pa);
    request_t r;
    r.virtual_address  = va;
    r.physical_address = pa;
    return r;
  endfunction

  // Table index drawn mostly from {0, 511} so walks reuse tables and reach the leaf;
  // a few fully random indices keep allocating until the page pool runs dry.
  function automatic logic [IDX_W-1:0] pick_index();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return IDX_W'($urandom_range(0, ENTRIES_PER_TABLE - 1));
    if (roll < 52) return '0;
    return IDX_LAST;
  endfunction

  function automatic request_t random_mapping();
    request_t r;
    r.virtual_address  = {$urandom, $urandom};
    r.physical_address = PA_W'({$urandom, $urandom});
    if ($urandom_range(0, 99) < 8) begin
      // noise: high index bits nonzero, block must skip it
      if (r.virtual_address[56:48] == '0)
        r.virtual_address[48 + $urandom_range(0, 8)] = 1'b1;
    end else begin
      // well-formed: bits 57..63 and the page offset stay random
      r.virtual_address[56:48] = '0;
      r.virtual_address[47:39] = pick_index();
      r.virtual_address[38:30] = pick_index();
      r.virtual_address[29:21] = pick_index();
    end
    return r;
  endfunction

  // One request transfer. Called at a falling edge, returns at a falling edge.
  // start stays high between back-to-back transfers.
  task automatic send(request_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Hold off until every outstanding result has come and the block is idle.
  task automatic drain();
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic write_base(logic [PA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    request   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    calm_left = 0;

    phase_base[0] = '0;
    phase_base[1] = PA_W'({$urandom, $urandom});
    phase_base[2] = 52'h0_0000_0000_2ABC;   // two pages up, low bits must be ignored
    phase_base[3] = 52'hF_FFFF_FFFF_FFFF;   // top of the address space, links wrap
    phase_base[4] = '0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Base 0. First map builds a full walk; the rest hit skips, reuse and
    // allocation at each level.
    write_base('0);
    send(mapping(64'h0000_0000_0000_0000, 52'h0_0000_0000_0000));
    send(mapping(64'h0000_0000_0000_0000, 52'hF_FFFF_FFFF_FFFF));
    send(mapping(64'hFFFF_FFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF));
    send(mapping(64'h0001_0000_0000_0000, 52'h0_0000_0000_1000));
    send(mapping(64'h0100_0000_0000_0ABC, 52'h0_0000_0000_2000));
    send(mapping(64'hFE00_FFFF_FFFF_FFFF, 52'h5_5555_5555_5555));
    send(mapping(64'h0000_FFFF_FFFF_F000, 52'hA_AAAA_AAAA_AAAA));
    send(mapping(64'h0000_0000_0020_0000, 52'h0_0000_0000_3000));
    send(mapping(64'h0000_0000_4000_0000, 52'h0_0000_0000_4000));
    send(mapping(64'h0000_0080_0000_0000, 52'h0_0000_0000_5000));
    send(mapping(64'h0000_0000_0000_1FFF, 52'h0_0000_0000_0001));

    // Base moved past the store: old links now point outside it,
    // new tables link relative to the new base.
    drain();
    write_base(52'h0_0000_0004_0000);
    send(mapping(64'h0000_0000_0000_0000, 52'h0_0000_0000_6000));
    send(mapping(64'h0000_0100_0000_0000, 52'h0_0000_0001_2000));
    send(mapping(64'h0000_0100_0000_1000, 52'h0_0000_0001_3000));

    // Base at the very top: link arithmetic wraps at 52 bits.
    drain();
    write_base(52'hF_FFFF_FFFF_FFFF);
    send(mapping(64'h0000_0000_0000_0000, 52'h0_0000_0000_7000));
    send(mapping(64'h0000_0100_0000_0000, 52'h0_0000_0000_8000));
    send(mapping(64'h0000_0180_0000_0000, 52'h0_0000_0000_9000));

    // Random phases, each under its own base; every phase boundary waits
    // for the block to drain before the register write.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_base(phase_base[p]);
      repeat (RANDOM_PER_PHASE) send(random_mapping());
    end

    drain();
    repeat (16) @(negedge clk);
    if (errors == 0) begin
      $display("** page_table_map_walker_top: PASSED **");
    end else begin
      $display("** page_table_map_walker_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> page_table_map_walker_top.f
hw/rtl/ptmw_pkg.sv
hw/rtl/ptmw_ram.sv
hw/rtl/ptmw_link_unit.sv
hw/rtl/page_table_map_walker_top.sv
tb/page_table_map_walker_checker.sv
tb/tb.sv
